### hdl/gdd_pkg.sv
// gdd_pkg: shared types, constants and calendar tables for the date difference core
// no dependencies; used by every file under hdl

package gdd_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned COUNT_W = 22;
    // day numbers reach about 366 * 2**YEAR_W, one bit more than the count
    localparam int unsigned DAYNUM_W = COUNT_W + 1;
    // quotient of a year by 100
    localparam int unsigned QUOT_W = 8;

    localparam int unsigned DEFAULT_MAX_YEAR = 9999;

    // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned RECIP_100   = 5243;

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LEAP,
        ST_SUM,
        ST_DIFF
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the request
        logic sel;     // 0 works on the first date, 1 on the second
        logic mul;     // year quotients by 100
        logic leap;    // leap flag and year base
        logic sum;     // day number and validity of the selected date
        logic diff;    // write the result register
    } cmd_t;

    // days in the months before month m of a common year
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        begin
            case (m)
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd59;
                4'd4:    r = 9'd90;
                4'd5:    r = 9'd120;
                4'd6:    r = 9'd151;
                4'd7:    r = 9'd181;
                4'd8:    r = 9'd212;
                4'd9:    r = 9'd243;
                4'd10:   r = 9'd273;
                4'd11:   r = 9'd304;
                4'd12:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        begin
            case (m)
                4'd2:                   r = leap ? DAY_W'(29) : DAY_W'(28);
                4'd4, 4'd6, 4'd9, 4'd11: r = DAY_W'(30);
                default:                r = DAY_W'(31);
            endcase
            return r;
        end
    endfunction

endpackage

### hdl/gdd_ctrl.sv
// gdd_ctrl: sequencer for the date difference core
// depends on gdd_pkg; drives gdd_datapath through gdd_pkg::cmd_t

module gdd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output gdd_pkg::cmd_t  cmd
);

    gdd_pkg::state_t state_reg, state_next;
    logic            sel_reg, sel_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdd_pkg::ST_IDLE;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.sel        = sel_reg;
        case (state_reg)
            gdd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    sel_next   = 1'b0;
                    state_next = gdd_pkg::ST_MUL;
                end
            end
            gdd_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = gdd_pkg::ST_LEAP;
            end
            gdd_pkg::ST_LEAP:
            begin
                cmd.leap   = 1'b1;
                state_next = gdd_pkg::ST_SUM;
            end
            gdd_pkg::ST_SUM:
            begin
                cmd.sum = 1'b1;
                if (sel_reg)
                begin
                    state_next = gdd_pkg::ST_DIFF;
                end
                else
                begin
                    sel_next   = 1'b1;
                    state_next = gdd_pkg::ST_MUL;
                end
            end
            gdd_pkg::ST_DIFF:
            begin
                // wait until the result register is free or being drained
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.diff       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = gdd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gdd_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != gdd_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### hdl/gdd_datapath.sv
// gdd_datapath: day number arithmetic, validity check and result register
// depends on gdd_pkg; sequenced by gdd_ctrl

module gdd_datapath #(
    parameter int unsigned MAX_YEAR = gdd_pkg::DEFAULT_MAX_YEAR
) (
    input  logic                         clk,
    input  gdd_pkg::cmd_t                cmd,
    input  logic [gdd_pkg::DAY_W-1:0]    first_day,
    input  logic [gdd_pkg::MONTH_W-1:0]  first_month,
    input  logic [gdd_pkg::YEAR_W-1:0]   first_year,
    input  logic [gdd_pkg::DAY_W-1:0]    second_day,
    input  logic [gdd_pkg::MONTH_W-1:0]  second_month,
    input  logic [gdd_pkg::YEAR_W-1:0]   second_year,
    output logic [gdd_pkg::COUNT_W-1:0]  day_count,
    output logic                         date_invalid
);

    localparam int unsigned YW = gdd_pkg::YEAR_W;
    localparam int unsigned QW = gdd_pkg::QUOT_W;
    localparam int unsigned NW = gdd_pkg::DAYNUM_W;
    localparam int unsigned CW = gdd_pkg::COUNT_W;
    localparam int unsigned PW = YW + gdd_pkg::RECIP_SHIFT;

    logic [gdd_pkg::DAY_W-1:0]   d1_reg, d2_reg;
    logic [gdd_pkg::MONTH_W-1:0] m1_reg, m2_reg;
    logic [YW-1:0]               y1_reg, y2_reg;
    logic [QW-1:0]               yq_reg, pq_reg;
    logic                        leap_reg;
    logic [NW-1:0]               base_reg;
    logic [NW-1:0]               na_reg, nb_reg;
    logic                        bad_reg;
    logic [CW-1:0]               count_reg;
    logic                        invalid_reg;

    logic [gdd_pkg::DAY_W-1:0]   d;
    logic [gdd_pkg::MONTH_W-1:0] m;
    logic [YW-1:0]               y, p, rem;
    logic [PW-1:0]               yprod, pprod;
    logic                        ok;
    logic [NW-1:0]               base_next, n_next, diff;

    assign d = cmd.sel ? d2_reg : d1_reg;
    assign m = cmd.sel ? m2_reg : m1_reg;
    assign y = cmd.sel ? y2_reg : y1_reg;
    assign p = y - YW'(1);

    // divide by 100 through a reciprocal multiply
    assign yprod = PW'(y) * PW'(gdd_pkg::RECIP_100);
    assign pprod = PW'(p) * PW'(gdd_pkg::RECIP_100);

    assign rem = y - YW'(yq_reg) * YW'(100);

    assign base_next = NW'(p) * NW'(365) + NW'(p >> 2) - NW'(pq_reg) + NW'(pq_reg >> 2);

    assign ok = (y != '0) && (32'(y) <= MAX_YEAR)
                && (m >= gdd_pkg::MONTH_JAN) && (m <= gdd_pkg::MONTH_DEC)
                && (d != '0) && (d <= gdd_pkg::month_len(m, leap_reg));

    assign n_next = base_reg + NW'(gdd_pkg::days_before(m))
                    + NW'((m > gdd_pkg::MONTH_FEB) && leap_reg) + NW'(d) - NW'(1);

    assign diff = (na_reg > nb_reg) ? (na_reg - nb_reg) : (nb_reg - na_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d1_reg <= first_day;
            m1_reg <= first_month;
            y1_reg <= first_year;
            d2_reg <= second_day;
            m2_reg <= second_month;
            y2_reg <= second_year;
        end
        if (cmd.mul)
        begin
            yq_reg <= yprod[gdd_pkg::RECIP_SHIFT +: QW];
            pq_reg <= pprod[gdd_pkg::RECIP_SHIFT +: QW];
        end
        if (cmd.leap)
        begin
            // divisible by 400 is divisible by 100 with a quotient divisible by 4
            leap_reg <= (y[1:0] == 2'b00) && ((rem != '0) || (yq_reg[1:0] == 2'b00));
            base_reg <= base_next;
        end
        if (cmd.sum)
        begin
            if (cmd.sel)
            begin
                nb_reg  <= n_next;
                bad_reg <= bad_reg || !ok;
            end
            else
            begin
                na_reg  <= n_next;
                bad_reg <= !ok;
            end
        end
        if (cmd.diff)
        begin
            invalid_reg <= bad_reg;
            if (bad_reg)
                count_reg <= '0;
            else if (diff[NW-1])
                count_reg <= '1;
            else
                count_reg <= diff[CW-1:0];
        end
    end

    assign day_count    = count_reg;
    assign date_invalid = invalid_reg;

endmodule

### hdl/gregorian_date_difference_core.sv
// gregorian_date_difference_core: top level of the date difference core
// depends on gdd_pkg, gdd_ctrl and gdd_datapath
//
// usage
//   input channel: one request carries two dates (day, month, year each);
//   it is taken at a rising edge with in_valid high and in_stall low
//   output channel: one result per request, day_count and date_invalid,
//   taken at a rising edge with out_valid high and out_stall low
//   each date becomes a day number counted from 1 January of year 1; the
//   result is the absolute difference, saturated to 22 bits
//   a date with a bad day, month or year (year above MAX_YEAR included)
//   gives date_invalid high and day_count zero
//   the shared day number unit takes three steps per date (quotient multiply,
//   leap and year base, month and day sum) and one more step forms the
//   difference; the core takes no new request until the last one is done
//   and it is back in idle; in_stall is high while a request is in work
//   a finished result sits in the output register while the next request
//   is taken; if the receiver still stalls when the next result is ready,
//   the core holds in its final step until the register drains
//   reset: asynchronous, active low; clears the sequencer and out_valid

module gregorian_date_difference_core #(
    parameter int unsigned MAX_YEAR = gdd_pkg::DEFAULT_MAX_YEAR
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [gdd_pkg::DAY_W-1:0]    first_day,
    input  logic [gdd_pkg::MONTH_W-1:0]  first_month,
    input  logic [gdd_pkg::YEAR_W-1:0]   first_year,
    input  logic [gdd_pkg::DAY_W-1:0]    second_day,
    input  logic [gdd_pkg::MONTH_W-1:0]  second_month,
    input  logic [gdd_pkg::YEAR_W-1:0]   second_year,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [gdd_pkg::COUNT_W-1:0]  day_count,
    output logic                         date_invalid
);

    gdd_pkg::cmd_t cmd;

    // sequencer: handshakes and step order
    gdd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // arithmetic and result register
    gdd_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .first_day    (first_day),
        .first_month  (first_month),
        .first_year   (first_year),
        .second_day   (second_day),
        .second_month (second_month),
        .second_year  (second_year),
        .day_count    (day_count),
        .date_invalid (date_invalid)
    );

endmodule

### hdl/gdd_checker.sv
// gdd_checker: port level assertions for gregorian_date_difference_core
// depends on gdd_pkg; bound to the top level at the end of this file

module gdd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [gdd_pkg::COUNT_W-1:0]  day_count,
    input logic                         date_invalid
);

    // a taken request blocks the next one: in_stall is high in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while previous one in work");

    // a result only appears at the end of a request's work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work in progress");

    // an invalid date carries a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && date_invalid) |-> (day_count == '0))
        else $error("invalid result with nonzero count");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(day_count) && $stable(date_invalid)))
        else $error("stalled result changed");

endmodule

bind gregorian_date_difference_core gdd_checker u_gdd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .day_count    (day_count),
    .date_invalid (date_invalid)
);

### tb/gregorian_date_difference_checker.sv
// gregorian_date_difference_checker: watches both channels of the date difference core,
// predicts each result from the accepted request and compares it field by field
// depends on gdd_pkg for the field widths

module gregorian_date_difference_checker #(
    parameter int unsigned LAST_YEAR = gdd_pkg::DEFAULT_MAX_YEAR
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [gdd_pkg::DAY_W-1:0]    first_day,
    input  logic [gdd_pkg::MONTH_W-1:0]  first_month,
    input  logic [gdd_pkg::YEAR_W-1:0]   first_year,
    input  logic [gdd_pkg::DAY_W-1:0]    second_day,
    input  logic [gdd_pkg::MONTH_W-1:0]  second_month,
    input  logic [gdd_pkg::YEAR_W-1:0]   second_year,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [gdd_pkg::COUNT_W-1:0]  day_count,
    input  logic                         date_invalid,
    output int                           fail_count,
    output int                           results_checked,
    output int                           invalid_results,
    output int                           pending
);

    localparam int unsigned COUNT_CEIL = (1 << gdd_pkg::COUNT_W) - 1;

    typedef struct packed {
        logic [gdd_pkg::COUNT_W-1:0] count;
        logic                        invalid;
    } span_t;

    span_t expected_spans[$];

    initial
    begin
        fail_count      = 0;
        results_checked = 0;
        invalid_results = 0;
        pending         = 0;
    end

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic bit calendar_ok(input int unsigned d, input int unsigned m,
                                       input int unsigned y);
        if (y < 1 || y > LAST_YEAR)
            return 1'b0;
        if (m < 1 || m > 12)
            return 1'b0;
        return (d >= 1) && (d <= days_in_month(m, y));
    endfunction

    // days since 1 january of year 1, months summed one by one
    function automatic int unsigned serial_day(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        int unsigned p;
        int unsigned n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++)
            n += days_in_month(k, y);
        return n + d - 1;
    endfunction

    function automatic span_t days_between(input int unsigned d1, input int unsigned m1,
                                           input int unsigned y1, input int unsigned d2,
                                           input int unsigned m2, input int unsigned y2);
        span_t       s;
        int unsigned a;
        int unsigned b;
        int unsigned gap;
        if (!calendar_ok(d1, m1, y1) || !calendar_ok(d2, m2, y2))
        begin
            s.count   = '0;
            s.invalid = 1'b1;
            return s;
        end
        a   = serial_day(d1, m1, y1);
        b   = serial_day(d2, m2, y2);
        gap = (a > b) ? a - b : b - a;
        if (gap > COUNT_CEIL)
            gap = COUNT_CEIL;
        s.count   = gap[gdd_pkg::COUNT_W-1:0];
        s.invalid = 1'b0;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        fail_count++;
        $display("mismatch %0d at result %0d: %s expected %0d got %0d",
                 fail_count, results_checked, what, want, got);
    endtask

    always @(posedge clk)
    begin : watch
        span_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_spans.push_back(days_between(first_day, first_month, first_year,
                                                      second_day, second_month, second_year));
            if (out_valid && !out_stall)
            begin
                if (expected_spans.size() == 0)
                    report_mismatch("result with no request pending, day_count", 0, day_count);
                else
                begin
                    want = expected_spans.pop_front();
                    if (day_count !== want.count)
                        report_mismatch("day_count", want.count, day_count);
                    if (date_invalid !== want.invalid)
                        report_mismatch("date_invalid", want.invalid, date_invalid);
                end
                results_checked++;
                if (date_invalid === 1'b1)
                    invalid_results++;
            end
            // updated late so the stimulus side reads a settled value at the edge
            pending <= expected_spans.size();
        end
    end

endmodule

### tb/gregorian_date_difference_core_test.sv
// gregorian_date_difference_core_test: top of the date difference core testbench
// depends on gdd_pkg, gregorian_date_difference_core and gregorian_date_difference_checker

module gregorian_date_difference_core_test;

    typedef struct packed {
        logic [gdd_pkg::DAY_W-1:0]   day;
        logic [gdd_pkg::MONTH_W-1:0] month;
        logic [gdd_pkg::YEAR_W-1:0]  year;
    } date_t;

    localparam int unsigned RANDOM_REQUESTS = 100;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [gdd_pkg::DAY_W-1:0]    first_day;
    logic [gdd_pkg::MONTH_W-1:0]  first_month;
    logic [gdd_pkg::YEAR_W-1:0]   first_year;
    logic [gdd_pkg::DAY_W-1:0]    second_day;
    logic [gdd_pkg::MONTH_W-1:0]  second_month;
    logic [gdd_pkg::YEAR_W-1:0]   second_year;
    logic                         out_valid;
    logic                         out_stall;
    logic [gdd_pkg::COUNT_W-1:0]  day_count;
    logic                         date_invalid;

    int fail_count;
    int results_checked;
    int invalid_results;
    int pending;

    int unsigned requests_sent;
    int unsigned directed_sent;

    // receiver side bookkeeping
    int unsigned stall_left;
    int unsigned results_taken;

    gregorian_date_difference_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_day    (first_day),
        .first_month  (first_month),
        .first_year   (first_year),
        .second_day   (second_day),
        .second_month (second_month),
        .second_year  (second_year),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .day_count    (day_count),
        .date_invalid (date_invalid)
    );

    // passive checker: predicts every accepted request and compares the results
    gregorian_date_difference_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .first_day       (first_day),
        .first_month     (first_month),
        .first_year      (first_year),
        .second_day      (second_day),
        .second_month    (second_month),
        .second_year     (second_year),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .day_count       (day_count),
        .date_invalid    (date_invalid),
        .fail_count      (fail_count),
        .results_checked (results_checked),
        .invalid_results (invalid_results),
        .pending         (pending)
    );

    // 20 time unit clock
    initial
        clk = 1'b0;
    always
        #10 clk = ~clk;

    // overall time limit, far above the slowest legal run
    initial
    begin
        #4000000;
        $display("gregorian_date_difference_core regression: fail");
        $finish;
    end

    // receiver: after each taken result draw a stall of random length, which may be zero;
    // every other block of 20 results runs with no stall at all
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall     <= 1'b0;
            stall_left    <= 0;
            results_taken <= 0;
        end
        else if (out_valid && !out_stall)
        begin : draw_stall
            int unsigned hold;
            hold = ((results_taken / 20) % 2 == 1) ? 0 : $urandom_range(0, 13);
            results_taken <= results_taken + 1;
            if (hold > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= hold - 1;
            end
            else
                out_stall <= 1'b0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
            out_stall <= 1'b0;
    end

    function automatic date_t make_date(input int unsigned d, input int unsigned m,
                                        input int unsigned y);
        date_t r;
        r.day   = d[gdd_pkg::DAY_W-1:0];
        r.month = m[gdd_pkg::MONTH_W-1:0];
        r.year  = y[gdd_pkg::YEAR_W-1:0];
        return r;
    endfunction

    // mostly well formed dates; days 29..31 now and then, which may run past month end
    function automatic date_t random_date();
        int unsigned d;
        d = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 28) : $urandom_range(29, 31);
        return make_date(d, $urandom_range(1, 12), $urandom_range(1, 9999));
    endfunction

    // present one request after an idle gap and hold it until taken;
    // called and returning at a rising edge, so valid gets one assignment per edge
    task automatic send_request(input date_t a, input date_t b, input int unsigned gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        first_day    <= a.day;
        first_month  <= a.month;
        first_year   <= a.year;
        second_day   <= b.day;
        second_month <= b.month;
        second_year  <= b.year;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    initial
    begin : stimulus
        date_t       a;
        date_t       b;
        date_t       dir_first[$];
        date_t       dir_second[$];
        int unsigned pick;
        int unsigned near_year;
        int unsigned gap;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        first_day     = '0;
        first_month   = '0;
        first_year    = '0;
        second_day    = '0;
        second_month  = '0;
        second_year   = '0;
        requests_sent = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: field extremes, leap rules and every kind of bad date
        // equal dates at both ends of the range
        dir_first.push_back(make_date(1, 1, 1));      dir_second.push_back(make_date(1, 1, 1));
        dir_first.push_back(make_date(31, 12, 9999)); dir_second.push_back(make_date(31, 12, 9999));
        // widest span, both orders
        dir_first.push_back(make_date(1, 1, 1));      dir_second.push_back(make_date(31, 12, 9999));
        dir_first.push_back(make_date(31, 12, 9999)); dir_second.push_back(make_date(1, 1, 1));
        // leap years: divisible by 400, by 4 only, and century years that are not leap
        dir_first.push_back(make_date(29, 2, 2000));  dir_second.push_back(make_date(1, 3, 2000));
        dir_first.push_back(make_date(29, 2, 2004));  dir_second.push_back(make_date(28, 2, 2100));
        dir_first.push_back(make_date(28, 2, 2001));  dir_second.push_back(make_date(1, 3, 2001));
        dir_first.push_back(make_date(15, 8, 2400));  dir_second.push_back(make_date(15, 8, 1600));
        dir_first.push_back(make_date(31, 12, 1999)); dir_second.push_back(make_date(1, 1, 2000));
        dir_first.push_back(make_date(31, 1, 1));     dir_second.push_back(make_date(1, 2, 1));
        dir_first.push_back(make_date(30, 4, 2020));  dir_second.push_back(make_date(31, 12, 2020));
        // day past month end
        dir_first.push_back(make_date(29, 2, 1900));  dir_second.push_back(make_date(1, 3, 1900));
        dir_first.push_back(make_date(1, 1, 2100));   dir_second.push_back(make_date(29, 2, 2100));
        dir_first.push_back(make_date(31, 4, 2020));  dir_second.push_back(make_date(1, 5, 2020));
        dir_first.push_back(make_date(15, 6, 1970));  dir_second.push_back(make_date(31, 6, 1970));
        // day zero
        dir_first.push_back(make_date(0, 5, 1984));   dir_second.push_back(make_date(1, 5, 1984));
        // month out of range
        dir_first.push_back(make_date(1, 0, 1984));   dir_second.push_back(make_date(1, 1, 1984));
        dir_first.push_back(make_date(1, 1, 1984));   dir_second.push_back(make_date(1, 13, 1984));
        dir_first.push_back(make_date(31, 15, 500));  dir_second.push_back(make_date(1, 1, 500));
        // year out of range: zero, just past the top, all ones
        dir_first.push_back(make_date(1, 1, 0));      dir_second.push_back(make_date(1, 1, 1));
        dir_first.push_back(make_date(1, 1, 10000));  dir_second.push_back(make_date(31, 12, 9999));
        dir_first.push_back(make_date(3, 3, 3));      dir_second.push_back(make_date(31, 12, 16383));

        directed_sent = dir_first.size();
        foreach (dir_first[k])
            send_request(dir_first[k], dir_second[k], $urandom_range(0, 13));

        // random part; requests 16..31, 48..63, ... go back to back
        for (int unsigned k = 0; k < RANDOM_REQUESTS; k++)
        begin
            pick = $urandom_range(0, 99);
            a    = random_date();
            if (pick < 60)
            begin
                // second date near the first: short spans and year boundaries
                b = random_date();
                near_year = a.year + $urandom_range(0, 4);
                near_year = (near_year < 3) ? 1 : near_year - 2;
                if (near_year > 9999)
                    near_year = 9999;
                b.year = near_year[gdd_pkg::YEAR_W-1:0];
            end
            else if (pick < 85)
                b = random_date();
            else
            begin
                // raw bits: mostly bad dates, all field bits exercised
                a = make_date($urandom, $urandom, $urandom);
                b = make_date($urandom, $urandom, $urandom);
            end
            gap = ((k / 16) % 2 == 1) ? 0 : $urandom_range(0, 13);
            send_request(a, b, gap);
        end
        in_valid <= 1'b0;

        // drain: every result in, then a margin past the core latency
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("sent %0d requests (%0d directed, %0d random); checked %0d results, %0d invalid",
                 requests_sent, directed_sent, RANDOM_REQUESTS, results_checked,
                 invalid_results);
        if (fail_count == 0)
            $display("gregorian_date_difference_core regression: pass");
        else
            $display("gregorian_date_difference_core regression: fail");
        $finish;
    end

endmodule
